@@ sv/bond_segment_geometry_core_defines.svh @@
`ifndef BOND_SEGMENT_GEOMETRY_CORE_DEFINES_SVH
`define BOND_SEGMENT_GEOMETRY_CORE_DEFINES_SVH

// same-cycle implication on the block clock, quiet during reset
`define BSG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication on the block clock, quiet during reset
`define BSG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bsg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsg_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = 33;
  localparam int SQ_W      = 66;
  localparam int ROOT_W    = 33;
  localparam int LEN_W     = 33;
  localparam int REM_W     = 36;
  localparam int DREM_W    = 35;
  localparam int Q_W       = FRAC_BITS + 1;
  localparam int DIR_W     = 18;
  localparam int QE_W      = (Q_W > DIR_W) ? Q_W : DIR_W;

  typedef struct packed {
    logic [COORD_W-1:0] mid;
    logic               neg_x;
    logic               neg_y;
    logic [DIFF_W-1:0]  mag_x;
    logic [DIFF_W-1:0]  mag_y;
  } seg_tag_t;

  typedef struct packed {
    seg_tag_t        tag;
    logic [SQ_W-1:0] rad;
  } sq_req_t;

  typedef struct packed {
    seg_tag_t         tag;
    logic [LEN_W-1:0] len;
  } len_req_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SQ_W-1:0]   rad;
  } rt_state_t;

  typedef struct packed {
    logic [DREM_W-1:0] r;
    logic [Q_W-1:0]    q;
  } dv_state_t;

  typedef struct packed {
    logic [COORD_W-1:0] mid;
    logic               neg_x;
    logic               neg_y;
    logic [LEN_W-1:0]   len;
    dv_state_t          sx;
    dv_state_t          sy;
  } dv_item_t;

  // one root digit: bring down two radicand bits, try root*4+1
  function automatic rt_state_t isqrt_step(rt_state_t s);
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    rt_state_t        n;
    t     = {s.rem[REM_W-3:0], s.rad[SQ_W-1 -: 2]};
    trial = REM_W'({s.root, 2'b01});
    n.rad = {s.rad[SQ_W-3:0], 2'b00};
    if (t >= trial) begin
      n.rem  = t - trial;
      n.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      n.rem  = t;
      n.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return n;
  endfunction

  // one quotient bit of mag * 2^FRAC_BITS / len, remainder kept below 2*len
  function automatic dv_state_t div_step(dv_state_t s, logic [LEN_W-1:0] len);
    logic [DREM_W-1:0] l;
    logic [DREM_W-1:0] r;
    logic              b;
    dv_state_t         n;
    l   = DREM_W'(len);
    b   = (s.r >= l);
    r   = b ? (s.r - l) : s.r;
    n.r = {r[DREM_W-2:0], 1'b0};
    n.q = {s.q[Q_W-2:0], b};
    return n;
  endfunction

  function automatic logic [DIR_W-1:0] sign_dir(logic [Q_W-1:0] q, logic neg);
    logic [QE_W-1:0]  qe;
    logic [DIR_W-1:0] m;
    qe = QE_W'(q);
    m  = qe[DIR_W-1:0];
    return neg ? (~m + 1'b1) : m;
  endfunction

endpackage

`default_nettype wire

@@ sv/bsg_seg_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bsg_seg_if import bsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] from_x;
  logic signed [COORD_W-1:0] from_y;
  logic signed [COORD_W-1:0] from_z;
  logic signed [COORD_W-1:0] to_x;
  logic signed [COORD_W-1:0] to_y;
  logic signed [COORD_W-1:0] to_z;

  modport source (output valid, from_x, from_y, from_z, to_x, to_y, to_z, input ready);
  modport sink   (input valid, from_x, from_y, from_z, to_x, to_y, to_z, output ready);
endinterface

`default_nettype wire

@@ sv/bsg_res_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bsg_res_if import bsg_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] mid_depth;
  logic [LEN_W-1:0]          seg_length;
  logic signed [DIR_W-1:0]   dir_x;
  logic signed [DIR_W-1:0]   dir_y;
  logic                      zero_length;

  modport source (output valid, mid_depth, seg_length, dir_x, dir_y, zero_length, input ready);
  modport sink   (input valid, mid_depth, seg_length, dir_x, dir_y, zero_length, output ready);
endinterface

`default_nettype wire

@@ sv/bsg_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsg_front import bsg_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic signed [COORD_W-1:0] from_x,
  input  wire logic signed [COORD_W-1:0] from_y,
  input  wire logic signed [COORD_W-1:0] from_z,
  input  wire logic signed [COORD_W-1:0] to_x,
  input  wire logic signed [COORD_W-1:0] to_y,
  input  wire logic signed [COORD_W-1:0] to_z,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output sq_req_t                        out_req
);

  typedef struct packed {
    logic [COORD_W-1:0] mid;
    logic [DIFF_W-1:0]  dx;
    logic [DIFF_W-1:0]  dy;
  } diff_t;

  typedef struct packed {
    seg_tag_t        tag;
    logic [SQ_W-1:0] sq_x;
    logic [SQ_W-1:0] sq_y;
  } sqr_t;

  logic     v1_r, v2_r, v3_r, v4_r;
  logic     rdy1, rdy2, rdy3, rdy4;
  diff_t    s1_r, s1_nxt;
  seg_tag_t s2_r, s2_nxt;
  sqr_t     s3_r, s3_nxt;
  sq_req_t  s4_r, s4_nxt;
  logic [DIFF_W-1:0] zsum;

  assign rdy4 = !v4_r || out_ready;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  // differences and floor mean of depth
  always_comb begin
    zsum       = {from_z[COORD_W-1], from_z} + {to_z[COORD_W-1], to_z};
    s1_nxt.mid = zsum[DIFF_W-1:1];
    s1_nxt.dx  = {to_x[COORD_W-1], to_x} - {from_x[COORD_W-1], from_x};
    s1_nxt.dy  = {to_y[COORD_W-1], to_y} - {from_y[COORD_W-1], from_y};
  end

  // magnitudes
  always_comb begin
    s2_nxt.mid   = s1_r.mid;
    s2_nxt.neg_x = s1_r.dx[DIFF_W-1];
    s2_nxt.neg_y = s1_r.dy[DIFF_W-1];
    s2_nxt.mag_x = s1_r.dx[DIFF_W-1] ? (~s1_r.dx + 1'b1) : s1_r.dx;
    s2_nxt.mag_y = s1_r.dy[DIFF_W-1] ? (~s1_r.dy + 1'b1) : s1_r.dy;
  end

  // squares
  always_comb begin
    s3_nxt.tag  = s2_r;
    s3_nxt.sq_x = SQ_W'(s2_r.mag_x) * SQ_W'(s2_r.mag_x);
    s3_nxt.sq_y = SQ_W'(s2_r.mag_y) * SQ_W'(s2_r.mag_y);
  end

  // sum of squares
  always_comb begin
    s4_nxt.tag = s3_r.tag;
    s4_nxt.rad = s3_r.sq_x + s3_r.sq_y;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)     s2_r <= s2_nxt;
    if (rdy3 && v2_r)     s3_r <= s3_nxt;
    if (rdy4 && v3_r)     s4_r <= s4_nxt;
  end

  assign out_valid = v4_r;
  assign out_req   = s4_r;

endmodule

`default_nettype wire

@@ sv/bsg_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsg_isqrt import bsg_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire sq_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_ready,
  output len_req_t      out_req
);

  typedef struct packed {
    seg_tag_t  tag;
    rt_state_t st;
  } sq_item_t;

  sq_item_t stg_r [ROOT_W];
  logic     v_r   [ROOT_W];
  logic     rdy   [ROOT_W+1];

  assign rdy[ROOT_W] = out_ready;
  assign in_ready    = rdy[0];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    sq_item_t src;
    sq_item_t stg_nxt;
    logic     src_v;

    if (i == 0) begin : g_first
      assign src.tag     = in_req.tag;
      assign src.st.rem  = '0;
      assign src.st.root = '0;
      assign src.st.rad  = in_req.rad;
      assign src_v       = in_valid;
    end else begin : g_rest
      assign src   = stg_r[i-1];
      assign src_v = v_r[i-1];
    end

    assign stg_nxt.tag = src.tag;
    assign stg_nxt.st  = isqrt_step(src.st);
    assign rdy[i]      = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) stg_r[i] <= stg_nxt;
    end
  end

  assign out_valid   = v_r[ROOT_W-1];
  assign out_req.tag = stg_r[ROOT_W-1].tag;
  assign out_req.len = stg_r[ROOT_W-1].st.root;

endmodule

`default_nettype wire

@@ sv/bsg_divide.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsg_divide import bsg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire len_req_t  in_req,
  output logic           out_valid,
  input  wire logic      out_ready,
  output dv_item_t       out_item
);

  dv_item_t stg_r [Q_W];
  logic     v_r   [Q_W];
  logic     rdy   [Q_W+1];

  assign rdy[Q_W]  = out_ready;
  assign in_ready  = rdy[0];

  for (genvar i = 0; i < Q_W; i++) begin : g_stage
    dv_item_t src;
    dv_item_t stg_nxt;
    logic     src_v;

    if (i == 0) begin : g_first
      assign src.mid   = in_req.tag.mid;
      assign src.neg_x = in_req.tag.neg_x;
      assign src.neg_y = in_req.tag.neg_y;
      assign src.len   = in_req.len;
      assign src.sx.r  = DREM_W'(in_req.tag.mag_x);
      assign src.sx.q  = '0;
      assign src.sy.r  = DREM_W'(in_req.tag.mag_y);
      assign src.sy.q  = '0;
      assign src_v     = in_valid;
    end else begin : g_rest
      assign src   = stg_r[i-1];
      assign src_v = v_r[i-1];
    end

    assign stg_nxt.mid   = src.mid;
    assign stg_nxt.neg_x = src.neg_x;
    assign stg_nxt.neg_y = src.neg_y;
    assign stg_nxt.len   = src.len;
    assign stg_nxt.sx    = div_step(src.sx, src.len);
    assign stg_nxt.sy    = div_step(src.sy, src.len);
    assign rdy[i]        = !v_r[i] || rdy[i+1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (rdy[i]) begin
        v_r[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i] && src_v) stg_r[i] <= stg_nxt;
    end
  end

  assign out_valid = v_r[Q_W-1];
  assign out_item  = stg_r[Q_W-1];

endmodule

`default_nettype wire

@@ sv/bond_segment_geometry_core.sv @@
// bond segment geometry: planar length, unit direction and mean depth of a
// segment given by two endpoints in signed q16.16
// in_seg carries one request (both endpoints); out_res returns one result
// per request, in order: floor mean depth, floor square root length of the
// planar difference, and the direction dx/len, dy/len truncated toward zero
// with FRAC_BITS fraction bits; coincident endpoints give a zero direction
// and raise zero_length
// stages: 4 front (difference, magnitude, square, sum), 33 root (one root
// bit each), FRAC_BITS+1 divide (one quotient bit each)
// throughput: one request per cycle unless out_res stalls, every stage holds its own valid bit
// stalls: each stage loads whenever it is empty or the stage after it moves,
// so a stalled receiver only fills bubbles and then holds in_seg.ready low;
// nothing is dropped or repeated
// reset: synchronous active-low rst_n empties every stage; data regs keep
// whatever they held
`timescale 1ns / 1ps
`default_nettype none
`include "bond_segment_geometry_core_defines.svh"

module bond_segment_geometry_core import bsg_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bsg_seg_if.sink    in_seg,
  bsg_res_if.source  out_res
);

  // front to root handoff
  logic     fr_v, fr_rdy;
  sq_req_t  fr_req;

  // root to divider handoff
  logic     sq_v, sq_rdy;
  len_req_t sq_req;

  // divider tail
  dv_item_t dv_item;
  logic     dv_zero;

  bsg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_seg.valid),
    .in_ready  (in_seg.ready),
    .from_x    (in_seg.from_x),
    .from_y    (in_seg.from_y),
    .from_z    (in_seg.from_z),
    .to_x      (in_seg.to_x),
    .to_y      (in_seg.to_y),
    .to_z      (in_seg.to_z),
    .out_valid (fr_v),
    .out_ready (fr_rdy),
    .out_req   (fr_req)
  );

  bsg_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_v),
    .in_ready  (fr_rdy),
    .in_req    (fr_req),
    .out_valid (sq_v),
    .out_ready (sq_rdy),
    .out_req   (sq_req)
  );

  bsg_divide u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sq_v),
    .in_ready  (sq_rdy),
    .in_req    (sq_req),
    .out_valid (out_res.valid),
    .out_ready (out_res.ready),
    .out_item  (dv_item)
  );

  // zero length means the divider ran on a zero divisor: mask its quotient
  assign dv_zero             = (dv_item.len == '0);
  assign out_res.mid_depth   = dv_item.mid;
  assign out_res.seg_length  = dv_item.len;
  assign out_res.zero_length = dv_zero;
  assign out_res.dir_x       = dv_zero ? '0 : sign_dir(dv_item.sx.q, dv_item.neg_x);
  assign out_res.dir_y       = dv_zero ? '0 : sign_dir(dv_item.sy.q, dv_item.neg_y);

  `BSG_ASSERT_NOW(a_zero_dir, out_res.valid && out_res.zero_length, (out_res.dir_x == '0) && (out_res.dir_y == '0), "zero length with nonzero direction")
  `BSG_ASSERT_NEXT(a_front_hold, fr_v && !fr_rdy, fr_v && (fr_req == $past(fr_req)), "front stage lost a stalled request")
  `BSG_ASSERT_NEXT(a_root_hold, sq_v && !sq_rdy, sq_v && (sq_req == $past(sq_req)), "root stage lost a stalled request")

endmodule

`default_nettype wire

@@ sim/tb_bond_segment_geometry_core.sv @@
`timescale 1ns / 1ps

module tb_bond_segment_geometry_core;
  import bsg_pkg::*;

  // one expected result of the geometry core
  typedef struct packed {
    logic [31:0] mid_depth;
    logic [32:0] seg_length;
    logic [17:0] dir_x;
    logic [17:0] dir_y;
    logic        zero_length;
  } geom_t;

  // one directed row: the endpoints plus an optional hand-typed answer
  typedef struct {
    logic [31:0] fx, fy, fz, tx, ty, tz;
    bit          typed;
    geom_t       res;
  } seg_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   errors = 0;
  int   sent = 0;
  int   got = 0;
  int   zero_seen = 0;
  bit   calm = 1'b0;
  geom_t geom_q[$];

  bsg_seg_if in_seg ();
  bsg_res_if out_res ();

  bond_segment_geometry_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_seg (in_seg.sink),
    .out_res(out_res.source)
  );

  always #5 clk = ~clk;

  initial begin
    #100_000_000;
    $display("timeout at %0t", $time);
    $display("tb_bond_segment_geometry_core: errors");
    $finish;
  end

  // floor square root of a 66-bit radicand, one root bit at a time
  function automatic logic [32:0] root_floor(logic [65:0] rad);
    logic [32:0] r;
    logic [32:0] c;
    r = '0;
    for (int b = 32; b >= 0; b--) begin
      c = r | (33'd1 << b);
      if (67'(c) * 67'(c) <= 67'(rad)) r = c;
    end
    return r;
  endfunction

  // truncated direction component, sign applied after the divide
  function automatic logic [17:0] dir_of(logic signed [32:0] d, logic [32:0] len);
    logic [32:0] mag;
    logic [63:0] q;
    mag = d[32] ? 33'(-d) : 33'(d);
    q = (64'(mag) << FRAC_BITS) / 64'(len);
    if (d[32]) q = -q;
    return q[17:0];
  endfunction

  function automatic geom_t segment_geometry(logic [31:0] fx, fy, fz, tx, ty, tz);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] zs;
    logic [32:0]        mx;
    logic [32:0]        my;
    geom_t              g;
    dx = 33'(signed'(tx)) - 33'(signed'(fx));
    dy = 33'(signed'(ty)) - 33'(signed'(fy));
    zs = 33'(signed'(fz)) + 33'(signed'(tz));
    mx = dx[32] ? 33'(-dx) : 33'(dx);
    my = dy[32] ? 33'(-dy) : 33'(dy);
    g.mid_depth = zs[32:1];
    g.seg_length = root_floor(66'(mx) * 66'(mx) + 66'(my) * 66'(my));
    if (g.seg_length == 0) begin
      g.dir_x = '0;
      g.dir_y = '0;
      g.zero_length = 1'b1;
    end else begin
      g.dir_x = dir_of(dx, g.seg_length);
      g.dir_y = dir_of(dy, g.seg_length);
      g.zero_length = 1'b0;
    end
    return g;
  endfunction

  // drive one request at the falling edge and hold it until accepted
  task automatic send_segment(logic [31:0] fx, fy, fz, tx, ty, tz);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_seg.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_seg.valid  <= 1'b1;
    in_seg.from_x <= fx;
    in_seg.from_y <= fy;
    in_seg.from_z <= fz;
    in_seg.to_x   <= tx;
    in_seg.to_y   <= ty;
    in_seg.to_z   <= tz;
    do @(posedge clk); while (!in_seg.ready);
    geom_q.push_back(segment_geometry(fx, fy, fz, tx, ty, tz));
    sent++;
    @(negedge clk);
  endtask

  // receiver stalls in random bursts, none once the run goes calm
  initial begin
    out_res.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_res.ready <= 1'b0;
        repeat ($urandom_range(1, 3) - 1) @(negedge clk);
      end else begin
        out_res.ready <= 1'b1;
      end
    end
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    geom_t e;
    if (rst_n && out_res.valid && out_res.ready) begin
      if (geom_q.size() == 0) begin
        errors++;
        $display("%0t unexpected result len=%h", $time, out_res.seg_length);
      end else begin
        e = geom_q.pop_front();
        got++;
        if (out_res.zero_length) zero_seen++;
        if (out_res.mid_depth !== e.mid_depth || out_res.seg_length !== e.seg_length ||
            out_res.dir_x !== e.dir_x || out_res.dir_y !== e.dir_y ||
            out_res.zero_length !== e.zero_length) begin
          errors++;
          $display("%0t mismatch exp mid=%h len=%h dx=%h dy=%h z=%b", $time,
                   e.mid_depth, e.seg_length, e.dir_x, e.dir_y, e.zero_length);
          $display("%0t          act mid=%h len=%h dx=%h dy=%h z=%b", $time,
                   out_res.mid_depth, out_res.seg_length, out_res.dir_x,
                   out_res.dir_y, out_res.zero_length);
        end
      end
    end
  end

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'(signed'($urandom_range(0, 8)) - 4);
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(0, 3)
                                     : 32'h8000_0000 + $urandom_range(0, 3);
      3: return 32'(signed'($urandom_range(0, 20'hfffff)) - 20'h80000);
      default: return $urandom() & 32'h0fff_ffff;
    endcase
  endfunction

  localparam logic [31:0] MAXC = 32'h7fff_ffff;
  localparam logic [31:0] MINC = 32'h8000_0000;
  localparam logic [31:0] ONE  = 32'h0001_0000;

  seg_row_t rows[$];
  seg_row_t r;
  logic [31:0] fx, fy, tx, ty;

  initial begin
    in_seg.valid = 1'b0;
    {in_seg.from_x, in_seg.from_y, in_seg.from_z} = '0;
    {in_seg.to_x, in_seg.to_y, in_seg.to_z} = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // coincident endpoints, unit axes, diagonal, extremes
    rows = '{
      '{'0, '0, '0, '0, '0, '0, 1'b1, '{'0, '0, '0, '0, 1'b1}},
      '{ONE, ONE, 32'd3, ONE, ONE, 32'd4, 1'b1, '{32'd3, '0, '0, '0, 1'b1}},
      '{'0, '0, '0, ONE, '0, '0, 1'b1, '{'0, 33'h1_0000, 18'h1_0000, '0, 1'b0}},
      '{'0, '0, '0, -ONE, '0, '0, 1'b1, '{'0, 33'h1_0000, 18'h3_0000, '0, 1'b0}},
      '{'0, '0, '0, '0, ONE, '0, 1'b1, '{'0, 33'h1_0000, '0, 18'h1_0000, 1'b0}},
      '{'0, '0, MAXC, '0, -ONE, MAXC, 1'b1, '{MAXC, 33'h1_0000, '0, 18'h3_0000, 1'b0}},
      '{'0, '0, MINC, 32'd1, '0, MINC, 1'b1, '{MINC, 33'd1, 18'h1_0000, '0, 1'b0}},
      '{MINC, MINC, MINC, MAXC, MAXC, MAXC, 1'b0, '{'0, '0, '0, '0, 1'b0}},
      '{MAXC, MAXC, MAXC, MINC, MINC, MINC, 1'b0, '{'0, '0, '0, '0, 1'b0}},
      '{MINC, '0, 32'hffff_ffff, MAXC, '0, '0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
      '{'0, MAXC, 32'd1, '0, MINC, 32'd0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
      '{'0, '0, '0, 32'h3_0000, 32'h4_0000, '0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
      '{'0, '0, '0, 32'hfffd_0000, 32'hfffc_0000, '0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
      '{'0, '0, '0, 32'd1, 32'd1, '0, 1'b0, '{'0, '0, '0, '0, 1'b0}},
      '{MAXC, MINC, 32'h5555_5555, MAXC, MINC, 32'haaaa_aaaa, 1'b0,
        '{'0, '0, '0, '0, 1'b0}}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_segment(r.fx, r.fy, r.fz, r.tx, r.ty, r.tz);
      // hand-typed answers must agree with the predictor too
      if (r.typed && geom_q[$] != r.res) begin
        errors++;
        $display("%0t directed row %0d: typed answer differs from prediction", $time, i);
        geom_q[$] = r.res;
      end
    end

    for (int n = 0; n < 450; n++) begin
      if (n == 380) calm = 1'b1;
      fx = rand_coord();
      fy = rand_coord();
      // a share of coincident or axis-aligned segments
      case ($urandom_range(0, 9))
        0: begin tx = fx; ty = fy; end
        1: begin tx = rand_coord(); ty = fy; end
        2: begin tx = fx; ty = rand_coord(); end
        default: begin tx = rand_coord(); ty = rand_coord(); end
      endcase
      send_segment(fx, fy, rand_coord(), tx, ty, rand_coord());
    end
    in_seg.valid <= 1'b0;

    // drain, then let the pipeline run quiet before the summary
    while (geom_q.size() != 0) @(posedge clk);
    repeat (2 * (38 + FRAC_BITS)) @(posedge clk);

    $display("sent %0d segments, checked %0d results, %0d with coincident endpoints",
             sent, got, zero_seen);
    $display("stalls and gaps on both channels, quiet stretch at the end");
    if (errors == 0) begin
      $display("tb_bond_segment_geometry_core: clean");
    end else begin
      $display("tb_bond_segment_geometry_core: errors");
    end
    $finish;
  end
endmodule
